@@ src/sdf_pkg.sv @@
package sdf_pkg;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'hBB;

  // Frame geometry. Positions count from the first sync byte.
  localparam logic [15:0] HEADER_LEN   = 16'd6;
  localparam logic [15:0] POS_HDR_BASE = 16'd2;
  localparam logic [15:0] POS_LEN_LOW  = 16'd5;

  // Index of the final result in a header burst.
  localparam logic [2:0] BURST_LAST = 3'd5;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Kind of work the back end has to do for one queued command.
  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_HEADER,
    KIND_DROP
  } sdf_kind_e;

  // One queued command. A header command carries frame bytes 2 to 4 in held
  // and byte 5 in data; a body command carries its byte in data.
  typedef struct packed {
    sdf_kind_e        kind;
    logic             last;
    logic [7:0]       data;
    logic [2:0][7:0]  held;
  } sdf_cmd_t;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } sdf_qstat_t;

endpackage

@@ src/sync_length_deframer.sv @@
// Channel  | Handshake              | Beat contents
// ---------+------------------------+-----------------------------------
// in       | in_valid_i / in_stall_o | in_byte_i
// out      | out_valid_o / out_stall_i | out_byte_o, out_last_o, out_drop_o
//
// One input beat is taken per cycle while the command queue has room.
// A header command gives six output beats, one per unstalled cycle; body bytes
// and drop markers give one beat each, so the output register sets the rate.
// The queue depth sets how long the input keeps flowing during a burst.
// Reset is asynchronous and active low; it clears the hunt state, the queue
// pointers and the output valid. The input stalls only when the queue is full.

module sync_length_deframer #(
  parameter int QueueDepth = sdf_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_drop_o
);

  // The front end hunts for the sync pair, gathers the header and turns
  // each meaningful beat into a command. Bytes before a sync produce none.
  sdf_pkg::sdf_cmd_t   push_cmd;
  sdf_pkg::sdf_cmd_t   head_cmd;
  sdf_pkg::sdf_qstat_t q_stat;
  logic                push;
  logic                pop;

  sdf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .q_stat_i   (q_stat),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // The queue lets the front keep taking beats while the back end replays
  // a header burst or waits on a stalled output.
  sdf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  // The back end walks each command into output beats through a registered
  // output stage.
  sdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .out_drop_o  (out_drop_o)
  );

endmodule

@@ src/sdf_front.sv @@
module sdf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  sdf_pkg::sdf_qstat_t q_stat_i,
  output logic              in_stall_o,
  output logic              push_o,
  output sdf_pkg::sdf_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC1,
    PH_HEADER,
    PH_BODY
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [15:0]     pos_q, pos_d;
  logic [15:0]     total_q, total_d;
  logic [2:0][7:0] held_q;
  logic            held_we;
  logic [1:0]      held_idx;
  logic            accept;
  logic [15:0]     hdr_off;
  logic [16:0]     pos_next;

  // Every byte waits while the queue is full, whether it makes a command or not.
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign hdr_off    = pos_q - sdf_pkg::POS_HDR_BASE;
  assign held_idx   = hdr_off[1:0];
  assign pos_next   = {1'b0, pos_q} + 17'd1;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    total_d      = total_q;
    held_we      = 1'b0;
    push_o       = 1'b0;
    cmd_o.kind   = sdf_pkg::KIND_BODY;
    cmd_o.last   = 1'b0;
    cmd_o.data   = in_byte_i;
    cmd_o.held   = held_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (in_byte_i == sdf_pkg::SYNC_FIRST) begin
            phase_d = PH_SYNC1;
          end
        end
        PH_SYNC1: begin
          if (in_byte_i == sdf_pkg::SYNC_SECOND) begin
            phase_d = PH_HEADER;
            pos_d   = sdf_pkg::POS_HDR_BASE;
          end else if (in_byte_i != sdf_pkg::SYNC_FIRST) begin
            phase_d = PH_HUNT;
          end
        end
        PH_HEADER: begin
          if (pos_q < sdf_pkg::POS_LEN_LOW) begin
            held_we = 1'b1;
            pos_d   = pos_next[15:0];
          end else begin
            total_d = {held_q[2], in_byte_i};
            push_o  = 1'b1;
            if (total_d < sdf_pkg::HEADER_LEN) begin
              cmd_o.kind = sdf_pkg::KIND_DROP;
              phase_d    = PH_HUNT;
              pos_d      = '0;
            end else begin
              cmd_o.kind = sdf_pkg::KIND_HEADER;
              cmd_o.last = (total_d == sdf_pkg::HEADER_LEN);
              if (total_d == sdf_pkg::HEADER_LEN) begin
                phase_d = PH_HUNT;
                pos_d   = '0;
              end else begin
                phase_d = PH_BODY;
                pos_d   = sdf_pkg::HEADER_LEN;
              end
            end
          end
        end
        PH_BODY: begin
          push_o     = 1'b1;
          cmd_o.kind = sdf_pkg::KIND_BODY;
          cmd_o.last = (pos_next >= {1'b0, total_q});
          if (cmd_o.last) begin
            phase_d = PH_HUNT;
            pos_d   = '0;
          end else begin
            pos_d   = pos_next[15:0];
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      total_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      total_q <= total_d;
    end
  end

  // Header bytes are written before they are read, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[held_idx] <= in_byte_i;
    end
  end

endmodule

@@ src/sdf_fifo.sv @@
module sdf_fifo #(
  parameter int Depth = sdf_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sdf_pkg::sdf_cmd_t   cmd_i,
  input  logic                pop_i,
  output sdf_pkg::sdf_cmd_t   head_o,
  output sdf_pkg::sdf_qstat_t stat_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  sdf_pkg::sdf_cmd_t slots_q [Depth];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("command pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

@@ src/sdf_back.sv @@
module sdf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdf_pkg::sdf_cmd_t   head_i,
  input  sdf_pkg::sdf_qstat_t q_stat_i,
  output logic                pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                out_drop_o
);

  logic [2:0] idx_q, idx_d;
  logic       load_en;
  logic       final_beat;
  logic [7:0] res_byte;
  logic       res_last;
  logic       res_drop;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, drop_q;

  assign load_en = !valid_q || !out_stall_i;

  always_comb begin
    res_byte   = head_i.data;
    res_last   = head_i.last;
    res_drop   = 1'b0;
    final_beat = 1'b1;
    case (head_i.kind)
      sdf_pkg::KIND_HEADER: begin
        final_beat = (idx_q == sdf_pkg::BURST_LAST);
        res_last   = head_i.last && final_beat;
        case (idx_q)
          3'd0:    res_byte = sdf_pkg::SYNC_FIRST;
          3'd1:    res_byte = sdf_pkg::SYNC_SECOND;
          3'd2:    res_byte = head_i.held[0];
          3'd3:    res_byte = head_i.held[1];
          3'd4:    res_byte = head_i.held[2];
          default: res_byte = head_i.data;
        endcase
      end
      sdf_pkg::KIND_DROP: begin
        res_byte = '0;
        res_last = 1'b0;
        res_drop = 1'b1;
      end
      default: begin
        res_byte = head_i.data;
      end
    endcase
  end

  assign pop_o = load_en && !q_stat_i.empty && final_beat;

  always_comb begin
    idx_d = idx_q;
    if (load_en && !q_stat_i.empty) begin
      idx_d = final_beat ? '0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load_en) begin
        valid_q <= !q_stat_i.empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      byte_q <= res_byte;
      last_q <= res_last;
      drop_q <= res_drop;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_drop_o  = drop_q;

`ifndef SYNTH
  a_drop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_drop_o) |-> (!out_last_o && out_byte_o == 8'd0))
    else $error("drop marker carries data or last");

  a_burst_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 3'd0) |-> (!q_stat_i.empty && head_i.kind == sdf_pkg::KIND_HEADER))
    else $error("burst index advanced without a header command at the head");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= sdf_pkg::BURST_LAST)
    else $error("burst index beyond the header length");
`endif

endmodule

@@ tb/tb_sync_length_deframer.sv @@
module tb_sync_length_deframer;

  // The run is bounded by a cycle count far above the slowest legal run. That run
  // has every beat waiting out the longest gap or stall on both sides.
  localparam int CycleLimit   = 400000;
  // Cycles to keep watching after the last expected beat, so that a stray
  // extra beat still has time to show up.
  localparam int DrainCycles  = 64;
  localparam int FramedTarget = 420;
  localparam int MaxReports   = 60;

  // Hunt state of the prediction, in the same four steps the block walks.
  typedef enum logic [1:0] {
    HUNT,
    SYNC_SEEN,
    IN_HEADER,
    IN_BODY
  } hunt_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drop;
  } frame_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       out_drop_o;

  sync_length_deframer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .out_drop_o (out_drop_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Byte stream still to be sent, and frame beats still owed by the block.
  logic [7:0]  stream_bytes[$];
  frame_beat_t expected_beats[$];

  // Prediction state. The held bytes are frame bytes 2 to 4 of the header
  // being collected. They are always written before the length is formed.
  hunt_state_e hunt_state = HUNT;
  logic [7:0]  held_bytes[3];
  logic [15:0] frame_pos   = 16'd0;
  logic [15:0] frame_total = 16'd0;

  int errors        = 0;
  int framed_bytes  = 0;
  int bytes_sent    = 0;
  int beats_checked = 0;
  int frames_closed = 0;
  int drops_seen    = 0;
  int cycle_count   = 0;

  // Idle draws. Mode 0 never idles, mode 1 spreads waits over the full range,
  // and mode 2 idles now and then. Each side switches its mode at random so
  // that the run has long stretches with no idling as well as heavy ones.
  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // Appends one byte to the stream still to be sent.
  function automatic void add_byte(logic [7:0] b);
    stream_bytes = {stream_bytes, b};
  endfunction

  function automatic void owe_beat(logic [7:0] data, logic last, logic drop);
    frame_beat_t beat;
    beat.data = data;
    beat.last = last;
    beat.drop = drop;
    expected_beats = {expected_beats, beat};
    if (last) frames_closed++;
  endfunction

  // Advances the prediction by one accepted byte and records the beats it
  // releases. A good header releases all six header bytes at once, on its
  // last header byte.
  function automatic void deframe_byte(logic [7:0] b);
    logic [15:0] length_field;
    logic        closes;
    case (hunt_state)
      HUNT: begin
        if (b == sdf_pkg::SYNC_FIRST) hunt_state = SYNC_SEEN;
      end
      SYNC_SEEN: begin
        // A second 0xFF keeps the hunt armed; anything but the second sync
        // byte or a further 0xFF throws the hunt back to the start.
        if (b == sdf_pkg::SYNC_SECOND) begin
          hunt_state = IN_HEADER;
          frame_pos  = sdf_pkg::POS_HDR_BASE;
        end else if (b != sdf_pkg::SYNC_FIRST) begin
          hunt_state = HUNT;
        end
      end
      IN_HEADER: begin
        if (frame_pos < sdf_pkg::POS_LEN_LOW) begin
          held_bytes[frame_pos - sdf_pkg::POS_HDR_BASE] = b;
          frame_pos = frame_pos + 16'd1;
        end else begin
          length_field = {held_bytes[2], b};
          frame_total  = length_field;
          if (length_field < sdf_pkg::HEADER_LEN) begin
            // A length too short to cover its own header becomes a drop marker.
            owe_beat(8'h00, 1'b0, 1'b1);
            drops_seen++;
            hunt_state = HUNT;
            frame_pos  = 16'd0;
          end else begin
            closes = (length_field == sdf_pkg::HEADER_LEN);
            owe_beat(sdf_pkg::SYNC_FIRST, 1'b0, 1'b0);
            owe_beat(sdf_pkg::SYNC_SECOND, 1'b0, 1'b0);
            owe_beat(held_bytes[0], 1'b0, 1'b0);
            owe_beat(held_bytes[1], 1'b0, 1'b0);
            owe_beat(held_bytes[2], 1'b0, 1'b0);
            owe_beat(b, closes, 1'b0);
            hunt_state = closes ? HUNT : IN_BODY;
            frame_pos  = closes ? 16'd0 : sdf_pkg::HEADER_LEN;
          end
        end
      end
      default: begin
        // Body bytes pass through untouched, a sync pair in the body included.
        closes = ({1'b0, frame_pos} + 17'd1 >= {1'b0, frame_total});
        owe_beat(b, closes, 1'b0);
        hunt_state = closes ? HUNT : IN_BODY;
        frame_pos  = closes ? 16'd0 : frame_pos + 16'd1;
      end
    endcase
  endfunction

  // Body bytes lean toward the sync values so that sync pairs show up inside
  // frames, where they must be carried as plain data.
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 7))
      0: return sdf_pkg::SYNC_FIRST;
      1: return sdf_pkg::SYNC_SECOND;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queues one whole frame with a random header. With a length of six or more,
  // the frame ends where its length field says; below that it has no body.
  task automatic queue_frame(logic [15:0] total);
    int body_count;
    body_count = (total > sdf_pkg::HEADER_LEN) ? int'(total - sdf_pkg::HEADER_LEN) : 0;
    add_byte(sdf_pkg::SYNC_FIRST);
    add_byte(sdf_pkg::SYNC_SECOND);
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    add_byte(total[15:8]);
    add_byte(total[7:0]);
    for (int i = 0; i < body_count; i++) add_byte(body_byte());
    framed_bytes += 6 + body_count;
  endtask

  // Input side. Each byte is held until accepted, and then the byte's own
  // idle draw is served before the next one goes out.
  int in_gap  = 0;
  int in_mode = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(in_byte_i);
        bytes_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // Stalled beat: the byte and its valid stay as they are.
      end else if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (stream_bytes.size() != 0) begin
        in_valid_i <= 1'b1;
        in_byte_i  <= stream_bytes.pop_front();
        in_gap     <= draw_wait(in_mode);
        if ($urandom_range(0, 31) == 0) in_mode <= $urandom_range(0, 2);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side. Every accepted beat is checked against the oldest owed beat.
  // Then the receiver holds off for that beat's own stall draw.
  int out_hold = 0;
  int out_mode = 0;

  always @(posedge clk_i) begin
    frame_beat_t want;
    int          stall_draw;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: beat with nothing owed: byte %02h last %b drop %b",
                     $time, out_byte_o, out_last_o, out_drop_o);
        end else begin
          want = expected_beats.pop_front();
          if (out_byte_o !== want.data) begin
            errors++;
            if (errors <= MaxReports)
              $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte_o);
          end
          if (out_last_o !== want.last) begin
            errors++;
            if (errors <= MaxReports)
              $display("%0t: out_last expected %b, got %b", $time, want.last, out_last_o);
          end
          if (out_drop_o !== want.drop) begin
            errors++;
            if (errors <= MaxReports)
              $display("%0t: out_drop expected %b, got %b", $time, want.drop, out_drop_o);
          end
        end
        stall_draw = draw_wait(out_mode);
        out_stall_i <= (stall_draw != 0);
        out_hold    <= (stall_draw != 0) ? stall_draw - 1 : 0;
        if ($urandom_range(0, 31) == 0) out_mode <= $urandom_range(0, 2);
      end else if (out_hold != 0) begin
        out_stall_i <= 1'b1;
        out_hold    <= out_hold - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog. A hang or a lost beat ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out with %0d beats still owed.", expected_beats.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // Directed opening: noise ahead of the hunt, a repeated first sync byte,
    // a frame of exactly six bytes, a broken sync, a short length that
    // becomes a drop marker, and a frame whose body carries a sync pair.
    logic [7:0] directed[26];
    int  pick;
    int  count;
    bit  long_done;
    directed = '{
      8'h00, 8'h55,
      8'hFF, 8'hFF, 8'hFF, 8'hBB, 8'h12, 8'h34, 8'h00, 8'h06,
      8'hFF, 8'h7A,
      8'hFF, 8'hBB, 8'hA5, 8'h5A, 8'h00, 8'h05,
      8'hFF, 8'hBB, 8'h01, 8'h02, 8'h00, 8'h08, 8'hFF, 8'hBB
    };
    long_done = 1'b0;
    foreach (directed[i]) add_byte(directed[i]);
    framed_bytes = 22;

    // Random part. Most of it is well-formed frames with random content.
    // The rest is noise, broken syncs, cut-off headers and short lengths.
    // One frame of 256 bytes exercises a nonzero length high byte.
    while (framed_bytes < FramedTarget) begin
      pick = $urandom_range(0, 15);
      if (!long_done && framed_bytes > FramedTarget / 4) begin
        queue_frame(16'h0100);
        long_done = 1'b1;
      end else if (pick == 0) begin
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++) add_byte(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        add_byte(sdf_pkg::SYNC_FIRST);
        add_byte(8'($urandom_range(0, 8'hBA)));
      end else if (pick == 2) begin
        // A header cut short: the next frame's bytes complete it instead.
        add_byte(sdf_pkg::SYNC_FIRST);
        add_byte(sdf_pkg::SYNC_SECOND);
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++) add_byte(8'($urandom_range(0, 255)));
        framed_bytes += 2 + count;
      end else if (pick <= 4) begin
        queue_frame(16'($urandom_range(0, 5)));
      end else if ($urandom_range(0, 7) == 0) begin
        queue_frame(16'(6 + $urandom_range(0, 40)));
      end else begin
        queue_frame(16'(6 + $urandom_range(0, 10)));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last byte to be taken, then for every owed beat.
    while (stream_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d stream bytes and checked %0d output beats.", bytes_sent, beats_checked);
    $display("Frames closed: %0d; short headers dropped: %0d.", frames_closed, drops_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
